// ===== rtl/aabb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pkg
// shared types and constants for the box pair collision resolve unit
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned ValW        = 31;
  localparam int unsigned SepW        = 32;
  localparam int unsigned ProdW       = 2 * ValW;
  localparam int unsigned TotW        = ValW + 1;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef struct packed {
    logic signed [SepW-1:0] sep_x;
    logic signed [SepW-1:0] sep_y;
    logic signed [SepW-1:0] sep_z;
    logic [ValW-1:0]        ext_sum_x;
    logic [ValW-1:0]        ext_sum_y;
    logic [ValW-1:0]        ext_sum_z;
    logic [ValW-1:0]        this_mass;
    logic [ValW-1:0]        other_mass;
  } in_word_t;

  typedef struct packed {
    logic            hit;
    logic [1:0]      axis;
    logic            negative_side;
    logic [ValW-1:0] penetration;
    logic [ValW-1:0] this_move;
    logic [ValW-1:0] other_move;
  } out_word_t;

  // word handed from cell to cell along the divider chain
  typedef struct packed {
    logic            vld;
    logic            hit;
    logic [1:0]      axis;
    logic            negative_side;
    logic [ValW-1:0] penetration;
    logic [TotW-1:0] divisor;
    logic [TotW:0]   rem;
    logic [ProdW-1:0] quo;
  } div_word_t;

endpackage

// ===== rtl/aabb_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_div_cell
// one restoring division step: shifts in the next dividend bit
// ----------------------------------------------------------------------------
module aabb_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  aabb_pkg::div_word_t word_i,
  output aabb_pkg::div_word_t word_o
);
  import aabb_pkg::*;

  div_word_t       word_d;
  div_word_t       word_q;
  logic [TotW+1:0] trial;
  logic [TotW+1:0] shifted;

  always_comb begin
    word_d  = word_i;
    shifted = {word_i.rem, word_i.quo[ProdW-1]};
    trial   = shifted - {1'b0, 1'b0, word_i.divisor};
    if (!trial[TotW+1]) begin
      word_d.rem = trial[TotW:0];
      word_d.quo = {word_i.quo[ProdW-2:0], 1'b1};
    end else begin
      word_d.rem = shifted[TotW:0];
      word_d.quo = {word_i.quo[ProdW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (adv_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

// ===== rtl/aabb_pair_collision_resolve_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pair_collision_resolve_unit
// overlap test, least penetration axis and mass weighted split
// ----------------------------------------------------------------------------
// channel | dir | word       | handshake
// in      | in  | in_word_t  | in_valid_i / in_stall_o
// out     | out | out_word_t | out_valid_o / out_stall_i
//
// one word per cycle while out is not stalled; the chain is the front stages plus one
// divider cell per quotient bit of the 62-bit product
// the whole chain advances together; a stall on out holds every stage
// and in_stall_o follows when the output register is full
// reset empties all stages
// ----------------------------------------------------------------------------
module aabb_pair_collision_resolve_unit #(
  parameter int unsigned FRAC_BITS = aabb_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  aabb_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aabb_pkg::out_word_t out_word_o
);
  import aabb_pkg::*;

  // format only: the mass split is a ratio
  localparam int unsigned FracUnused = FRAC_BITS;

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // stage 1: magnitudes, penetrations, axis pick
  logic [SepW-1:0] mag [3];
  logic            neg [3];
  logic [ValW-1:0] ext [3];
  logic [SepW:0]   dif [3];
  logic            ovl [3];
  logic [ValW-1:0] pen [3];
  logic [1:0]      ax;

  always_comb begin
    ext[0] = in_word_i.ext_sum_x;
    ext[1] = in_word_i.ext_sum_y;
    ext[2] = in_word_i.ext_sum_z;
    neg[0] = in_word_i.sep_x[SepW-1];
    neg[1] = in_word_i.sep_y[SepW-1];
    neg[2] = in_word_i.sep_z[SepW-1];
    mag[0] = neg[0] ? -in_word_i.sep_x : in_word_i.sep_x;
    mag[1] = neg[1] ? -in_word_i.sep_y : in_word_i.sep_y;
    mag[2] = neg[2] ? -in_word_i.sep_z : in_word_i.sep_z;
    for (int i = 0; i < 3; i++) begin
      dif[i] = {2'b00, ext[i]} - {1'b0, mag[i]};
      ovl[i] = !dif[i][SepW] && (dif[i][SepW-1:0] != '0);
      pen[i] = dif[i][ValW-1:0];
    end
    if (pen[0] < pen[1] && pen[0] < pen[2]) begin
      ax = AxisX;
    end else if (pen[1] < pen[0] && pen[1] < pen[2]) begin
      ax = AxisY;
    end else begin
      ax = AxisZ;
    end
  end

  logic            s1_vld_q;
  logic            s1_hit_q;
  logic [1:0]      s1_axis_q;
  logic            s1_neg_q;
  logic [ValW-1:0] s1_pen_q;
  logic [ValW-1:0] s1_mt_q;
  logic [ValW-1:0] s1_mo_q;
  logic            hit;

  assign hit = ovl[0] && ovl[1] && ovl[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_hit_q  <= hit;
      s1_axis_q <= hit ? ax : AxisX;
      s1_neg_q  <= hit && neg[ax];
      s1_pen_q  <= hit ? pen[ax] : '0;
      s1_mt_q   <= in_word_i.this_mass;
      s1_mo_q   <= in_word_i.other_mass;
    end
  end

  // stage 2: product and divisor; zero total gives p*1/2
  logic [TotW-1:0] tot;
  logic            tot_zero;
  div_word_t       chain [ProdW+1];

  assign tot      = {1'b0, s1_mt_q} + {1'b0, s1_mo_q};
  assign tot_zero = (tot == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain[0] <= '0;
    end else if (adv) begin
      chain[0].vld           <= s1_vld_q;
      chain[0].hit           <= s1_hit_q;
      chain[0].axis          <= s1_axis_q;
      chain[0].negative_side <= s1_neg_q;
      chain[0].penetration   <= s1_pen_q;
      chain[0].divisor       <= tot_zero ? TotW'(2) : tot;
      chain[0].rem           <= '0;
      chain[0].quo           <= s1_pen_q * (tot_zero ? ValW'(1) : s1_mo_q);
    end
  end

  for (genvar g = 0; g < ProdW; g++) begin : g_cell
    aabb_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .word_i (chain[g]),
      .word_o (chain[g+1])
    );
  end

  div_word_t last;
  assign last = chain[ProdW];

  assign out_valid_o              = last.vld;
  assign out_word_o.hit           = last.hit;
  assign out_word_o.axis          = last.axis;
  assign out_word_o.negative_side = last.negative_side;
  assign out_word_o.penetration   = last.penetration;
  assign out_word_o.this_move     = last.quo[ValW-1:0];
  assign out_word_o.other_move    = last.penetration - last.quo[ValW-1:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.hit |-> out_word_o.penetration == '0)
    else $error("miss with nonzero penetration");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.this_move <= out_word_o.penetration)
    else $error("move exceeds penetration");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.axis != 2'd3)
    else $error("bad axis code");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(out_word_o) || (FracUnused == 0))
    else $error("output changed while held");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives box pairs into the collision resolve unit, predicts each result word
// (hit, least penetration axis, side and mass split) and checks it in order
// ----------------------------------------------------------------------------
module tb;
  import aabb_pkg::*;

  localparam int unsigned LatCycles = 80;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned NumRandom = 500;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  in_word_t  pend_q[$];
  out_word_t resolve_q[$];
  int        errors = 0;
  int        idle_cnt = 0;
  int        gap_cnt = 0;
  int        stall_cnt = 0;
  bit        hold_off = 0;
  bit        drain_req = 0;
  bit        feed_done = 0;

  aabb_pair_collision_resolve_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic out_word_t resolve_pair(in_word_t w);
    out_word_t r;
    logic [32:0] mag[3];
    logic [32:0] ext[3];
    logic [32:0] pen[3];
    logic        neg[3];
    logic [31:0] sep[3];
    logic        hit;
    logic [1:0]  ax;
    logic [31:0] tot;
    logic [63:0] prod;
    logic [30:0] p;
    logic [30:0] tm;
    sep[0] = w.sep_x; sep[1] = w.sep_y; sep[2] = w.sep_z;
    ext[0] = {2'b00, w.ext_sum_x};
    ext[1] = {2'b00, w.ext_sum_y};
    ext[2] = {2'b00, w.ext_sum_z};
    hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      neg[i] = sep[i][31];
      mag[i] = neg[i] ? 33'h100000000 - {1'b0, sep[i]} : {1'b0, sep[i]};
      if (mag[i] < ext[i]) begin
        pen[i] = ext[i] - mag[i];
      end else begin
        hit = 1'b0;
        pen[i] = '0;
      end
    end
    r = '0;
    if (!hit) return r;
    if (pen[0] < pen[1] && pen[0] < pen[2]) ax = AxisX;
    else if (pen[1] < pen[0] && pen[1] < pen[2]) ax = AxisY;
    else ax = AxisZ;
    p = pen[ax][30:0];
    tot = {1'b0, w.this_mass} + {1'b0, w.other_mass};
    if (tot == 0) begin
      tm = p >> 1;
    end else begin
      prod = (64'(p) * 64'(w.other_mass)) / 64'(tot);
      tm = prod[30:0];
    end
    r.hit = 1'b1;
    r.axis = ax;
    r.negative_side = neg[ax];
    r.penetration = p;
    r.this_move = tm;
    r.other_move = p - tm;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic [30:0] rand31();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 255));
      1: return 31'h7fffffff - 31'($urandom_range(0, 255));
      default: return 31'($urandom);
    endcase
  endfunction

  // mostly overlapping pairs with small separation versus extent
  function automatic in_word_t rand_pair();
    in_word_t w;
    logic [30:0] e;
    logic [31:0] s;
    bit          overlap;
    overlap = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < 3; i++) begin
      e = rand31();
      if (overlap && e != 0) s = 32'($urandom_range(0, e - 1));
      else s = {1'b0, rand31()};
      if ($urandom_range(0, 1)) s = -s;
      if ($urandom_range(0, 49) == 0) s = $urandom;
      case (i)
        0: begin w.sep_x = s; w.ext_sum_x = e; end
        1: begin w.sep_y = s; w.ext_sum_y = e; end
        default: begin w.sep_z = s; w.ext_sum_z = e; end
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      w.ext_sum_y = w.ext_sum_x;
      w.sep_y = w.sep_x;
    end
    w.this_mass = rand31();
    w.other_mass = rand31();
    if ($urandom_range(0, 29) == 0) w.this_mass = '0;
    if ($urandom_range(0, 29) == 0) w.other_mass = '0;
    return w;
  endfunction

  function automatic in_word_t mk(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                  logic [30:0] ex, logic [30:0] ey, logic [30:0] ez,
                                  logic [30:0] mt, logic [30:0] mo);
    in_word_t w;
    w.sep_x = sx; w.sep_y = sy; w.sep_z = sz;
    w.ext_sum_x = ex; w.ext_sum_y = ey; w.ext_sum_z = ez;
    w.this_mass = mt; w.other_mass = mo;
    return w;
  endfunction

  initial begin
    // no overlap, all zero
    pend_q.push_back(mk(32'd100, 0, 0, 31'd50, 31'd50, 31'd50, 31'd1, 31'd1));
    // separation equal to extent is no overlap
    pend_q.push_back(mk(32'd50, 0, 0, 31'd50, 31'd60, 31'd70, 31'd1, 31'd1));
    // most negative separation
    pend_q.push_back(mk(32'h80000000, 0, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                        31'd3, 31'd5));
    // x least, negative side
    pend_q.push_back(mk(-32'd40, 32'd1, 32'd1, 31'd50, 31'd50, 31'd50, 31'd2, 31'd3));
    // y least, positive side
    pend_q.push_back(mk(32'd1, 32'd45, -32'd1, 31'd50, 31'd50, 31'd50, 31'd7, 31'd1));
    // ties fall through to z
    pend_q.push_back(mk(32'd10, 32'd10, 32'd0, 31'd50, 31'd50, 31'd50, 31'd1, 31'd1));
    pend_q.push_back(mk(0, 0, 0, 31'd9, 31'd9, 31'd9, 31'd1, 31'd2));
    pend_q.push_back(mk(0, -32'd5, 0, 31'd9, 31'd9, 31'd4, 31'd1, 31'd2));
    // zero separation counts as positive
    pend_q.push_back(mk(0, 32'd1, 32'd1, 31'd3, 31'd100, 31'd100, 31'd1, 31'd1));
    // both masses zero, one mass zero
    pend_q.push_back(mk(0, 0, 0, 31'd7, 31'd100, 31'd100, 31'd0, 31'd0));
    pend_q.push_back(mk(0, 0, 0, 31'd7, 31'd100, 31'd100, 31'd0, 31'd5));
    pend_q.push_back(mk(0, 0, 0, 31'd7, 31'd100, 31'd100, 31'd5, 31'd0));
    // max extents and masses
    pend_q.push_back(mk(32'h7fffffff, -32'h7fffffff, 0, 31'h7fffffff, 31'h7fffffff,
                        31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    pend_q.push_back(mk(0, 0, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                        31'd1, 31'h7fffffff));
    pend_q.push_back(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff,
                        31'h7ffffffe, 31'h7fffffff, 31'h7fffffff, 31'd1));
    for (int i = 0; i < NumRandom; i++) pend_q.push_back(rand_pair());
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
      gap_cnt <= 0;
      hold_off <= 1'b0;
      drain_req <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        resolve_q.push_back(resolve_pair(in_word_i));
        if (pend_q.size() == 260) drain_req <= 1'b1;
      end
      if (drain_req && !hold_off) begin
        hold_off <= 1'b1;
        in_valid_i <= 1'b0;
      end else if (hold_off) begin
        in_valid_i <= 1'b0;
        if (resolve_q.size() == 0) begin
          hold_off <= 1'b0;
          drain_req <= 1'b0;
        end
      end else if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_word_i <= pend_q.pop_front();
        gap_cnt <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
        feed_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (resolve_q.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_word_o);
          errors++;
        end else begin
          exp_w = resolve_q.pop_front();
          if (out_word_o.hit !== exp_w.hit || out_word_o.axis !== exp_w.axis ||
              out_word_o.negative_side !== exp_w.negative_side ||
              out_word_o.penetration !== exp_w.penetration ||
              out_word_o.this_move !== exp_w.this_move ||
              out_word_o.other_move !== exp_w.other_move) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_w, out_word_o);
            errors++;
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_stall_i <= 1'b1;
      end else begin
        stall_cnt <= gap_len();
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchLimit) begin
        $display("** aabb_pair_collision_resolve_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    wait (feed_done);
    wait (resolve_q.size() == 0);
    repeat (LatCycles) @(posedge clk_i);
    if (errors == 0 && resolve_q.size() == 0) begin
      $display("** aabb_pair_collision_resolve_unit: PASSED **");
    end else begin
      $display("** aabb_pair_collision_resolve_unit: FAILED **");
    end
    $finish;
  end

endmodule
